// ----- hw/rtl/chkd_pkg.sv -----
// shared constants, types and helpers for the chunked body decoder
package chkd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int HEX_BITS  = 4;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_FRAMING  = 2'd2
    } t_err;

    // one decoded result per input byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       data_valid;
        logic       body_done;
        t_err       error_code;
    } t_chkd_res;

    // hex digit decode: valid flag and nibble value
    typedef struct packed {
        logic                is_hex;
        logic [HEX_BITS-1:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex r;
        r.is_hex = 1'b1;
        r.value  = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.value = HEX_BITS'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.value = HEX_BITS'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.value = HEX_BITS'(b - 8'h37);
        end else begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/chkd_in_if.sv -----
// input channel: raw body bytes
interface chkd_in_if import chkd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/chkd_out_if.sv -----
// output channel: decoded result per byte
interface chkd_out_if import chkd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       data_valid;
    logic       body_done;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output data_valid, output body_done,
                    output error_code, input ready);
    modport sink   (input valid, input out_byte, input data_valid, input body_done,
                    input error_code, output ready);
endinterface

// ----- hw/rtl/chkd_core.sv -----
// framing state and per-byte decode logic
module chkd_core import chkd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  logic [7:0] i_byte,
    output t_chkd_res o_res
);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_remaining, n_remaining;
    t_err                 r_err, n_err;
    t_hex                 hex;
    logic                 is_cr, is_lf;

    assign hex   = hex_decode(i_byte);
    assign is_cr = (i_byte == BYTE_CR);
    assign is_lf = (i_byte == BYTE_LF);

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_err       = r_err;
        o_res.out_byte   = '0;
        o_res.data_valid = 1'b0;
        if (r_err == ERR_NONE) begin
            unique case (r_phase)
                PH_SIZE: begin
                    if (hex.is_hex) begin
                        if (r_remaining[SIZE_BITS-1 -: HEX_BITS] != '0) begin
                            n_err = ERR_OVERFLOW;
                        end else begin
                            n_remaining = {r_remaining[SIZE_BITS-HEX_BITS-1:0], hex.value};
                        end
                    end else if (is_cr) begin
                        n_phase = PH_SIZE_LF;
                    end else if (is_lf) begin
                        n_err = ERR_FRAMING;
                    end else begin
                        n_phase = PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (is_cr) begin
                        n_phase = PH_SIZE_LF;
                    end else if (is_lf) begin
                        n_err = ERR_FRAMING;
                    end
                end
                PH_SIZE_LF: begin
                    if (!is_lf) begin
                        n_err = ERR_FRAMING;
                    end else if (r_remaining == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_res.out_byte   = i_byte;
                    o_res.data_valid = 1'b1;
                    n_remaining      = r_remaining - SIZE_BITS'(1);
                    if (r_remaining == SIZE_BITS'(1)) begin
                        n_phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    if (is_cr) begin
                        n_phase = PH_DATA_LF;
                    end else begin
                        n_err = ERR_FRAMING;
                    end
                end
                PH_DATA_LF: begin
                    if (is_lf) begin
                        n_phase     = PH_SIZE;
                        n_remaining = '0;
                    end else begin
                        n_err = ERR_FRAMING;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
        o_res.error_code = n_err;
        o_res.body_done  = (n_err == ERR_NONE) && (n_phase == PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_remaining <= '0;
            r_err       <= ERR_NONE;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_err       <= n_err;
        end
    end

endmodule

// ----- hw/rtl/http_chunked_body_decoder.sv -----
// top level of the chunked body decoder: handshake and result register
//
// channel   dir  payload                                     transfer when
// i_in      in   in_byte[7:0]                                valid && ready
// o_out     out  out_byte[7:0] data_valid body_done          valid && ready
//                error_code[1:0]
//
// one byte per cycle while the output is taken; each accepted byte yields exactly one result
// the result is registered, so it appears in the cycle after the byte transfer
// framing state lives in chkd_core and advances only on an input transfer
// reset (synchronous, active low) returns to the size-line phase with no error
// while a result waits unread the input still takes a byte if the result is
// taken in the same cycle; otherwise i_in.ready drops until it is
module http_chunked_body_decoder import chkd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chkd_in_if.sink    i_in,
    chkd_out_if.source o_out
);

    logic      take;
    t_chkd_res step_res;
    t_chkd_res r_res;
    logic      r_out_valid;

    // free slot when the output register is empty or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    chkd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.in_byte),
        .o_res   (step_res)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= take;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= step_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_res.out_byte;
    assign o_out.data_valid = r_res.data_valid;
    assign o_out.body_done  = r_res.body_done;
    assign o_out.error_code = r_res.error_code;

endmodule

// ----- hw/rtl/chkd_checker.sv -----
// port-level checks for the chunked body decoder, bound to the top level
module chkd_checker import chkd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_data_valid,
    input logic       i_body_done,
    input logic [1:0] i_error_code
);

    logic       out_xfer;
    logic       r_err_seen;
    logic [1:0] r_last_err;

    assign out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
            r_last_err <= ERR_NONE;
        end else if (out_xfer && !r_err_seen && i_error_code != ERR_NONE) begin
            r_err_seen <= 1'b1;
            r_last_err <= i_error_code;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
        && $stable(i_data_valid) && $stable(i_body_done) && $stable(i_error_code))
        else $error("stalled result changed");

    // payload only when clean and not finished
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_data_valid |-> i_error_code == ERR_NONE && !i_body_done)
        else $error("data byte with error or after body end");

    // non-payload results carry a zero byte, done excludes error
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_out_byte == 8'h00
        && !(i_body_done && i_error_code != ERR_NONE))
        else $error("bad non-data result");

    // errors are sticky across transfers
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_err_seen |-> i_error_code == r_last_err && !i_body_done)
        else $error("error code changed after being raised");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder chkd_checker u_chkd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_data_valid (o_out.data_valid),
    .i_body_done  (o_out.body_done),
    .i_error_code (o_out.error_code)
);
